@@ rtl/ecc_point_arithmetic_gfp_top_macros.svh @@
// assertion macros for the gf(p) point unit
// used by epa_alu and ecc_point_arithmetic_gfp_top, expects clk and rst in scope
`ifndef ECC_POINT_ARITHMETIC_GFP_TOP_MACROS_SVH
`define ECC_POINT_ARITHMETIC_GFP_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EPA_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define EPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EPA_ASSERT_HOLD(label, ante, cons, msg)
`define EPA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/epa_pkg.sv @@
// shared types and constants for the gf(p) point unit
// no dependencies
`default_nettype none

package epa_pkg;

  // fixed widths of the scalar and the configuration port
  localparam int SCALAR_W = 32;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;

  // operations of the shared modular unit
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_INV
  } alu_op_t;

  // request from the sequencer to the modular unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

`default_nettype wire

@@ rtl/epa_alu.sv @@
// shared modular arithmetic unit: add, sub, bit-serial multiply, euclid inverse
// depends on epa_pkg and the macro header
`default_nettype none
`include "ecc_point_arithmetic_gfp_top_macros.svh"

module epa_alu #(
  parameter int W = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  epa_pkg::alu_req_t  req,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  input  logic [W-1:0]       p,
  output logic               done,
  output logic [W-1:0]       res
);

  localparam int XW = W + 3;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_CHK,
    A_DIV,
    A_UPD,
    A_FIX
  } alu_state_t;

  alu_state_t st;
  logic [W-1:0] acc_r, mplr, mcand;
  logic [CW-1:0] cnt;
  logic [W-1:0] aa, mm, rem, dvd;
  logic signed [XW-1:0] x, y, qy;

  logic deg;
  logic [W:0] pz, sum, sum_r, dif, dif_r;
  logic [W:0] t_dbl, t_dbl_r, t_add, t_add_r;
  logic [W:0] rt, rdiff;
  logic qb;
  logic [W-1:0] rem_next;
  logic signed [XW-1:0] qy_next, pext, xa, xf;
  logic done_next;

  // combinational datapath
  always_comb begin
    deg = (p < W'(2));
    pz  = {1'b0, p};
    // modular add and subtract of reduced operands
    sum   = {1'b0, a} + {1'b0, b};
    sum_r = (sum >= pz) ? sum - pz : sum;
    dif   = {1'b0, a} + pz - {1'b0, b};
    dif_r = (dif >= pz) ? dif - pz : dif;
    // one multiply step: acc = 2*acc + bit*mcand mod p
    t_dbl   = {acc_r, 1'b0};
    t_dbl_r = (t_dbl >= pz) ? t_dbl - pz : t_dbl;
    t_add   = t_dbl_r + (mplr[W-1] ? {1'b0, mcand} : '0);
    t_add_r = (t_add >= pz) ? t_add - pz : t_add;
    // one restoring division step with quotient times y accumulated
    rt       = {rem, dvd[W-1]};
    qb       = (rt >= {1'b0, mm});
    rdiff    = rt - {1'b0, mm};
    rem_next = qb ? rdiff[W-1:0] : rt[W-1:0];
    qy_next  = (qy <<< 1) + (qb ? y : '0);
    // final coefficient reduction
    pext = $signed({3'b000, p});
    xa   = x[XW-1] ? x + pext : x;
    xf   = (xa >= pext) ? xa - pext : xa;
    // completion flag for the next cycle
    done_next = 1'b0;
    case (st)
      A_IDLE: begin
        done_next = req.start & (deg | (req.op == epa_pkg::ALU_ADD) |
                                 (req.op == epa_pkg::ALU_SUB));
      end
      A_MUL:   done_next = (cnt == CW'(1));
      A_FIX:   done_next = 1'b1;
      default: done_next = 1'b0;
    endcase
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= A_IDLE;
      done <= 1'b0;
    end else begin
      done <= done_next;
      case (st)
        A_IDLE: begin
          if (req.start) begin
            if (deg) begin
              res <= '0;
            end else begin
              case (req.op)
                epa_pkg::ALU_ADD: begin
                  res <= sum_r[W-1:0];
                end
                epa_pkg::ALU_SUB: begin
                  res <= dif_r[W-1:0];
                end
                epa_pkg::ALU_MUL: begin
                  acc_r <= '0;
                  mplr  <= a;
                  mcand <= b;
                  cnt   <= CW'(W);
                  st    <= A_MUL;
                end
                default: begin
                  aa <= a;
                  mm <= p;
                  x  <= XW'(1);
                  y  <= '0;
                  st <= A_CHK;
                end
              endcase
            end
          end
        end
        A_MUL: begin
          acc_r <= t_add_r[W-1:0];
          mplr  <= mplr << 1;
          cnt   <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            res <= t_add_r[W-1:0];
            st  <= A_IDLE;
          end
        end
        A_CHK: begin
          if (aa > W'(1) && mm != '0) begin
            rem <= '0;
            dvd <= aa;
            qy  <= '0;
            cnt <= CW'(W);
            st  <= A_DIV;
          end else begin
            st <= A_FIX;
          end
        end
        A_DIV: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          qy  <= qy_next;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            st <= A_UPD;
          end
        end
        A_UPD: begin
          mm <= rem;
          aa <= mm;
          y  <= x - qy;
          x  <= y;
          st <= A_CHK;
        end
        A_FIX: begin
          res <= xf[W-1:0];
          st  <= A_IDLE;
        end
        default: st <= A_IDLE;
      endcase
    end
  end

  `EPA_ASSERT_HOLD(a_start_when_idle, req.start, st == A_IDLE, "alu start while busy")
  `EPA_ASSERT_HOLD(a_rem_below_divisor, st == A_DIV, rem < mm, "partial remainder out of range")
  `EPA_ASSERT_NEXT(a_mul_ends, st == A_MUL && cnt == CW'(1), done && st == A_IDLE, "multiply did not end")

endmodule

`default_nettype wire

@@ rtl/ecc_point_arithmetic_gfp_top.sv @@
// affine point unit over gf(p): add, double, signed scalar multiply, on-curve check
// depends on epa_pkg, epa_alu and the macro header
//
//   channel  handshake                    payload
//   in       in_valid / in_ready          kind p_x p_y p_inf q_x q_y q_inf scalar
//   out      out_valid / out_ready        r_x r_y r_inf on_curve
//   cfg      psel penable pwrite pready   paddr pwdata prdata
//
// every field op goes through one shared modular unit: add, sub, a bit-serial multiply,
// and an inverse built from a bit-serial division per euclid step.
// a lone add or double is dominated by the euclid divider;
// a scalar multiply runs up to 32 add/double rounds.
// rst is synchronous; registers return to modulus 97, a 2, b 3.
// in_ready is high only while idle; a finished result waits in the output register.
`default_nettype none
`include "ecc_point_arithmetic_gfp_top_macros.svh"

module ecc_point_arithmetic_gfp_top #(
  parameter int FIELD_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [FIELD_BITS-1:0]          p_x,
  input  logic [FIELD_BITS-1:0]          p_y,
  input  logic                           p_inf,
  input  logic [FIELD_BITS-1:0]          q_x,
  input  logic [FIELD_BITS-1:0]          q_y,
  input  logic                           q_inf,
  input  logic signed [epa_pkg::SCALAR_W-1:0] scalar,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [FIELD_BITS-1:0]          r_x,
  output logic [FIELD_BITS-1:0]          r_y,
  output logic                           r_inf,
  output logic                           on_curve,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [epa_pkg::APB_AW-1:0]     paddr,
  input  logic [epa_pkg::APB_DW-1:0]     pwdata,
  output logic [epa_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int W  = FIELD_BITS;
  localparam int KW = epa_pkg::SCALAR_W;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DBL = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_CHK = 2'd3;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_CURVE_A = 2'd1;
  localparam logic [1:0] REG_CURVE_B = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE,
    S_RED_PX, S_RED_PY, S_RED_QX, S_RED_QY, S_RED_A, S_RED_B,
    S_DISPATCH,
    S_ADD_CHK, S_ADD_SUMY, S_ADD_EQ,
    S_ADD_NUM, S_ADD_DEN, S_ADD_INV, S_ADD_LAM, S_ADD_LSQ,
    S_ADD_SX1, S_ADD_SX2, S_ADD_DX, S_ADD_MY, S_ADD_Y,
    S_DBL_CHK, S_DBL_XSQ, S_DBL_X3, S_DBL_NUM, S_DBL_DEN, S_DBL_INV,
    S_DBL_LAM, S_DBL_LSQ, S_DBL_X2, S_DBL_RX, S_DBL_DX, S_DBL_MY, S_DBL_Y,
    S_MUL_TEST, S_MUL_DBL, S_MUL_SHIFT, S_NEG,
    S_CRV_CHK, S_CRV_YSQ, S_CRV_XSQ, S_CRV_X3, S_CRV_AX, S_CRV_S1, S_CRV_S2,
    S_CRV_CMP,
    S_FINISH
  } state_t;

  state_t state, nxt;

  // configuration registers
  logic [W-1:0] modulus, curve_a, curve_b;

  // working registers
  logic [W-1:0] ax, ay, bx, by, t0, t1, lam, cx, ca, cb;
  logic ainf, binf, dsel, run, neg, onc;
  logic [1:0] op_kind;
  logic [KW-1:0] mag, kmag;

  // modular unit interface
  epa_pkg::alu_req_t alu_req;
  epa_pkg::alu_op_t  alu_op;
  logic              op_en, alu_done;
  logic [W-1:0]      opa, opb, alu_res;

  logic [W-1:0] sx, sy;
  logic         sinf, cfg_wr;
  state_t       add_next, dbl_next;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign cfg_wr   = psel & penable & pwrite & pready;

  // register read
  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_MODULUS: prdata = epa_pkg::APB_DW'(modulus);
      REG_CURVE_A: prdata = epa_pkg::APB_DW'(curve_a);
      REG_CURVE_B: prdata = epa_pkg::APB_DW'(curve_b);
      default:     prdata = '0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(97);
      curve_a <= W'(2);
      curve_b <= W'(3);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODULUS: modulus <= pwdata[W-1:0];
        REG_CURVE_A: curve_a <= pwdata[W-1:0];
        REG_CURVE_B: curve_b <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // point being doubled and the return paths
  always_comb begin
    sx       = dsel ? bx : ax;
    sy       = dsel ? by : ay;
    sinf     = dsel ? binf : ainf;
    add_next = (op_kind == KIND_MUL) ? S_MUL_DBL : S_FINISH;
    dbl_next = dsel ? S_MUL_SHIFT : add_next;
    kmag     = scalar[KW-1] ? ('0 - $unsigned(scalar)) : $unsigned(scalar);
  end

  // field op issued in each arithmetic state
  always_comb begin
    op_en  = 1'b0;
    alu_op = epa_pkg::ALU_ADD;
    opa    = '0;
    opb    = '0;
    nxt    = state;
    case (state)
      S_RED_PX: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = ax; opb = W'(1); nxt = S_RED_PY; end
      S_RED_PY: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = ay; opb = W'(1); nxt = S_RED_QX; end
      S_RED_QX: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = bx; opb = W'(1); nxt = S_RED_QY; end
      S_RED_QY: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = by; opb = W'(1); nxt = S_RED_A; end
      S_RED_A: begin
        op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = curve_a; opb = W'(1); nxt = S_RED_B;
      end
      S_RED_B: begin
        op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = curve_b; opb = W'(1); nxt = S_DISPATCH;
      end
      // chord addition
      S_ADD_SUMY: begin op_en = 1'b1; alu_op = epa_pkg::ALU_ADD; opa = ay; opb = by; nxt = S_ADD_EQ; end
      S_ADD_NUM: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = by; opb = ay; nxt = S_ADD_DEN; end
      S_ADD_DEN: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = bx; opb = ax; nxt = S_ADD_INV; end
      S_ADD_INV: begin op_en = 1'b1; alu_op = epa_pkg::ALU_INV; opa = t1; nxt = S_ADD_LAM; end
      S_ADD_LAM: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = t0; opb = t1; nxt = S_ADD_LSQ; end
      S_ADD_LSQ: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = lam; opb = lam; nxt = S_ADD_SX1; end
      S_ADD_SX1: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = t0; opb = ax; nxt = S_ADD_SX2; end
      S_ADD_SX2: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = t0; opb = bx; nxt = S_ADD_DX; end
      S_ADD_DX: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = ax; opb = cx; nxt = S_ADD_MY; end
      S_ADD_MY: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = lam; opb = t0; nxt = S_ADD_Y; end
      S_ADD_Y: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = t0; opb = ay; nxt = add_next; end
      // tangent doubling
      S_DBL_XSQ: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = sx; opb = sx; nxt = S_DBL_X3; end
      S_DBL_X3: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = W'(3); opb = t0; nxt = S_DBL_NUM; end
      S_DBL_NUM: begin op_en = 1'b1; alu_op = epa_pkg::ALU_ADD; opa = t0; opb = ca; nxt = S_DBL_DEN; end
      S_DBL_DEN: begin op_en = 1'b1; alu_op = epa_pkg::ALU_ADD; opa = sy; opb = sy; nxt = S_DBL_INV; end
      S_DBL_INV: begin op_en = 1'b1; alu_op = epa_pkg::ALU_INV; opa = t1; nxt = S_DBL_LAM; end
      S_DBL_LAM: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = t0; opb = t1; nxt = S_DBL_LSQ; end
      S_DBL_LSQ: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = lam; opb = lam; nxt = S_DBL_X2; end
      S_DBL_X2: begin op_en = 1'b1; alu_op = epa_pkg::ALU_ADD; opa = sx; opb = sx; nxt = S_DBL_RX; end
      S_DBL_RX: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = t0; opb = t1; nxt = S_DBL_DX; end
      S_DBL_DX: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = sx; opb = cx; nxt = S_DBL_MY; end
      S_DBL_MY: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = lam; opb = t0; nxt = S_DBL_Y; end
      S_DBL_Y: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = t0; opb = sy; nxt = dbl_next; end
      // negation for a negative scalar
      S_NEG: begin op_en = 1'b1; alu_op = epa_pkg::ALU_SUB; opa = '0; opb = ay; nxt = S_FINISH; end
      // curve equation
      S_CRV_YSQ: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = ay; opb = ay; nxt = S_CRV_XSQ; end
      S_CRV_XSQ: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = ax; opb = ax; nxt = S_CRV_X3; end
      S_CRV_X3: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = t1; opb = ax; nxt = S_CRV_AX; end
      S_CRV_AX: begin op_en = 1'b1; alu_op = epa_pkg::ALU_MUL; opa = ca; opb = ax; nxt = S_CRV_S1; end
      S_CRV_S1: begin op_en = 1'b1; alu_op = epa_pkg::ALU_ADD; opa = t1; opb = lam; nxt = S_CRV_S2; end
      S_CRV_S2: begin op_en = 1'b1; alu_op = epa_pkg::ALU_ADD; opa = t1; opb = cb; nxt = S_CRV_CMP; end
      default: ;
    endcase
    alu_req.start = op_en & ~run;
    alu_req.op    = alu_op;
  end

  epa_alu #(
    .W (W)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (opa),
    .b    (opb),
    .p    (modulus),
    .done (alu_done),
    .res  (alu_res)
  );

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run       <= 1'b0;
      dsel      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output transfer, unless a new result loads in the same cycle
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      if (op_en) begin
        // arithmetic state: issue, then take the result
        if (!run) begin
          run <= 1'b1;
        end else if (alu_done) begin
          run   <= 1'b0;
          state <= nxt;
          case (state)
            S_RED_PX, S_RED_PY, S_RED_QX, S_RED_QY: begin
              if (state == S_RED_PX) ax <= alu_res;
              if (state == S_RED_PY) ay <= alu_res;
              if (state == S_RED_QX) bx <= alu_res;
              if (state == S_RED_QY) by <= alu_res;
            end
            S_RED_A: ca <= alu_res;
            S_RED_B: cb <= alu_res;
            S_ADD_LAM, S_DBL_LAM, S_CRV_AX: lam <= alu_res;
            S_ADD_SX2, S_DBL_RX: cx <= alu_res;
            S_ADD_DEN, S_ADD_INV, S_DBL_DEN, S_DBL_INV, S_DBL_X2,
            S_CRV_XSQ, S_CRV_X3, S_CRV_S1, S_CRV_S2: t1 <= alu_res;
            S_ADD_Y: begin
              ax   <= cx;
              ay   <= alu_res;
              ainf <= 1'b0;
            end
            S_DBL_Y: begin
              if (dsel) begin
                bx   <= cx;
                by   <= alu_res;
                binf <= 1'b0;
              end else begin
                ax   <= cx;
                ay   <= alu_res;
                ainf <= 1'b0;
              end
            end
            S_NEG: ay <= alu_res;
            default: t0 <= alu_res;
          endcase
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              ax      <= p_x;
              ay      <= p_y;
              ainf    <= p_inf;
              bx      <= q_x;
              by      <= q_y;
              binf    <= q_inf;
              op_kind <= kind;
              mag     <= kmag;
              neg     <= scalar[KW-1];
              onc     <= 1'b0;
              dsel    <= 1'b0;
              state   <= S_RED_PX;
            end
          end
          S_DISPATCH: begin
            case (op_kind)
              KIND_ADD: state <= S_ADD_CHK;
              KIND_DBL: state <= S_DBL_CHK;
              KIND_MUL: begin
                // accumulator starts at infinity, addend is p
                bx    <= ax;
                by    <= ay;
                binf  <= ainf;
                ainf  <= 1'b1;
                state <= S_MUL_TEST;
              end
              default: state <= S_CRV_CHK;
            endcase
          end
          S_ADD_CHK: begin
            dsel <= 1'b0;
            if (ainf) begin
              ax    <= bx;
              ay    <= by;
              ainf  <= binf;
              state <= add_next;
            end else if (binf) begin
              state <= add_next;
            end else if (ax == bx) begin
              state <= S_ADD_SUMY;
            end else begin
              state <= S_ADD_NUM;
            end
          end
          S_ADD_EQ: begin
            // opposite points give infinity, equal points double
            if (t0 == '0) begin
              ainf  <= 1'b1;
              state <= add_next;
            end else begin
              state <= S_DBL_CHK;
            end
          end
          S_DBL_CHK: begin
            if (sinf || sy == '0) begin
              if (dsel) binf <= 1'b1;
              else      ainf <= 1'b1;
              state <= dbl_next;
            end else begin
              state <= S_DBL_XSQ;
            end
          end
          S_MUL_TEST: begin
            if (mag == '0) begin
              state <= (neg && !ainf) ? S_NEG : S_FINISH;
            end else if (mag[0]) begin
              state <= S_ADD_CHK;
            end else begin
              state <= S_MUL_DBL;
            end
          end
          S_MUL_DBL: begin
            dsel  <= 1'b1;
            state <= S_DBL_CHK;
          end
          S_MUL_SHIFT: begin
            dsel  <= 1'b0;
            mag   <= mag >> 1;
            state <= S_MUL_TEST;
          end
          S_CRV_CHK: begin
            if (ainf) begin
              onc   <= 1'b1;
              state <= S_FINISH;
            end else begin
              state <= S_CRV_YSQ;
            end
          end
          S_CRV_CMP: begin
            onc   <= (t0 == t1);
            state <= S_FINISH;
          end
          S_FINISH: begin
            if (!out_valid || out_ready) begin
              r_x       <= (op_kind != KIND_CHK && !ainf) ? ax : '0;
              r_y       <= (op_kind != KIND_CHK && !ainf) ? ay : '0;
              r_inf     <= (op_kind != KIND_CHK) & ainf;
              on_curve  <= (op_kind == KIND_CHK) & onc;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `EPA_ASSERT_HOLD(a_done_only_when_waiting, alu_done, run && op_en, "unit result with no op waiting")
  `EPA_ASSERT_NEXT(a_finish_loads_output, state == S_FINISH && (!out_valid || out_ready), out_valid && state == S_IDLE, "result not loaded")
  `EPA_ASSERT_HOLD(a_check_result_clean, out_valid && on_curve, !r_inf && r_x == '0 && r_y == '0, "check result carries a point")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking bench for the gf(p) affine point unit: add, double, scalar multiply, curve check
// depends on epa_pkg and ecc_point_arithmetic_gfp_top; holds its own point predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int FW = 31;
  localparam longint CYCLE_LIMIT = 40_000_000;

  // operation codes of the kind field
  typedef enum logic [1:0] {
    OP_ADD,
    OP_DBL,
    OP_MUL,
    OP_CHK
  } op_kind_t;

  // register byte addresses
  localparam logic [epa_pkg::APB_AW-1:0] REG_MODULUS = 4'd0;
  localparam logic [epa_pkg::APB_AW-1:0] REG_CURVE_A = 4'd4;
  localparam logic [epa_pkg::APB_AW-1:0] REG_CURVE_B = 4'd8;

  typedef struct {
    op_kind_t    kind;
    logic [30:0] px, py, qx, qy;
    logic        pinf, qinf;
    logic [31:0] k;
  } op_item_t;

  typedef struct {
    logic [30:0] x, y;
    logic        inf, onc;
  } point_res_t;

  typedef struct {
    logic [63:0] x, y;
    logic        inf;
  } gf_point_t;

  // predictor and store of expected points
  class ecc_ledger;
    logic [63:0] fmod, ca, cb;
    point_res_t  pending_pts[$];
    int          errors;

    function new();
      fmod = 97; ca = 2; cb = 3; errors = 0;
    endfunction

    function logic [63:0] red(logic [63:0] v);
      if (fmod < 2) return 0;
      return v % fmod;
    endfunction

    function logic [63:0] msub(logic [63:0] u, logic [63:0] v);
      return red(u + fmod - v);
    endfunction

    function logic [63:0] mmul(logic [63:0] u, logic [63:0] v);
      return red(u * v);
    endfunction

    // extended euclid, stops when the dividend drops to one or below or the remainder hits zero
    function logic [63:0] minv(logic [63:0] v);
      longint m0, mm, aa, x, y, q, t;
      if (fmod < 2) return 0;
      m0 = longint'(fmod); mm = m0; aa = longint'(v % fmod);
      x = 1; y = 0;
      while (aa > 1) begin
        if (mm == 0) break;
        q = aa / mm; t = mm; mm = aa % mm; aa = t;
        t = y; y = x - q * y; x = t;
      end
      x = x % m0;
      if (x < 0) x += m0;
      return 64'(x);
    endfunction

    function gf_point_t pinf_pt();
      gf_point_t r;
      r.x = 0; r.y = 0; r.inf = 1;
      return r;
    endfunction

    function gf_point_t dbl(gf_point_t p);
      gf_point_t r;
      logic [63:0] num, den, lam;
      if (p.inf || p.y == 0) return pinf_pt();
      num = red(mmul(3, mmul(p.x, p.x)) + red(ca));
      den = red(2 * p.y);
      lam = mmul(num, minv(den));
      r.x = msub(mmul(lam, lam), red(2 * p.x));
      r.y = msub(mmul(lam, msub(p.x, r.x)), p.y);
      r.inf = 0;
      return r;
    endfunction

    function gf_point_t add(gf_point_t p, gf_point_t q);
      gf_point_t r;
      logic [63:0] num, den, lam;
      if (p.inf) return q;
      if (q.inf) return p;
      if (p.x == q.x) begin
        if (red(p.y + q.y) == 0) return pinf_pt();
        return dbl(p);
      end
      num = msub(q.y, p.y);
      den = msub(q.x, p.x);
      lam = mmul(num, minv(den));
      r.x = msub(msub(mmul(lam, lam), p.x), q.x);
      r.y = msub(mmul(lam, msub(p.x, r.x)), p.y);
      r.inf = 0;
      return r;
    endfunction

    // lsb-first double and add on |k|, y negated for negative k
    function gf_point_t mult(logic [31:0] k, gf_point_t p);
      gf_point_t r, q;
      logic neg;
      logic [31:0] mag;
      r = pinf_pt(); q = p;
      neg = k[31];
      mag = neg ? 32'd0 - k : k;
      while (mag != 0) begin
        if (mag[0]) r = add(r, q);
        q = dbl(q);
        mag = mag >> 1;
      end
      if (neg && !r.inf) r.y = msub(0, r.y);
      return r;
    endfunction

    function logic on_curve_pt(gf_point_t p);
      if (p.inf) return 1;
      return mmul(p.y, p.y) ==
             red(mmul(mmul(p.x, p.x), p.x) + mmul(red(ca), p.x) + red(cb));
    endfunction

    function void set_reg(logic [epa_pkg::APB_AW-1:0] addr, logic [31:0] v);
      case (addr)
        REG_MODULUS: fmod = v[30:0];
        REG_CURVE_A: ca = v[30:0];
        REG_CURVE_B: cb = v[30:0];
        default: ;
      endcase
    endfunction

    // accepted input transfer: work out the expected point
    function void note_op(op_item_t it);
      gf_point_t p, q, r;
      point_res_t e;
      e.onc = 0;
      p.x = red(it.px); p.y = red(it.py); p.inf = it.pinf;
      q.x = red(it.qx); q.y = red(it.qy); q.inf = it.qinf;
      case (it.kind)
        OP_ADD: r = add(p, q);
        OP_DBL: r = dbl(p);
        OP_MUL: r = mult(it.k, p);
        default: begin
          e.onc = on_curve_pt(p);
          r.x = 0; r.y = 0; r.inf = 0;
        end
      endcase
      if (r.inf) begin
        r.x = 0; r.y = 0;
      end
      e.x = r.x[30:0]; e.y = r.y[30:0]; e.inf = r.inf;
      pending_pts.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // accepted output transfer against the oldest expected point
    task check_point(point_res_t got);
      point_res_t e;
      if (pending_pts.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending_pts.pop_front();
      if (got.x !== e.x) report($sformatf("r_x got %0d exp %0d", got.x, e.x));
      if (got.y !== e.y) report($sformatf("r_y got %0d exp %0d", got.y, e.y));
      if (got.inf !== e.inf) report($sformatf("r_inf got %0b exp %0b", got.inf, e.inf));
      if (got.onc !== e.onc) report($sformatf("on_curve got %0b exp %0b", got.onc, e.onc));
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] kind;
  logic [FW-1:0] p_x, p_y, q_x, q_y, r_x, r_y;
  logic p_inf, q_inf, r_inf, on_curve;
  logic signed [epa_pkg::SCALAR_W-1:0] scalar;
  logic psel, penable, pwrite, pready;
  logic [epa_pkg::APB_AW-1:0] paddr;
  logic [epa_pkg::APB_DW-1:0] pwdata, prdata;

  ecc_ledger ledger;
  longint cycles;
  int hold_cycles;

  ecc_point_arithmetic_gfp_top #(.FIELD_BITS(FW)) dut (.*);

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // monitors on both channels
  always @(posedge clk) begin
    op_item_t it;
    point_res_t got;
    if (!rst && in_valid && in_ready) begin
      it.kind = op_kind_t'(kind); it.px = p_x; it.py = p_y; it.pinf = p_inf;
      it.qx = q_x; it.qy = q_y; it.qinf = q_inf; it.k = scalar;
      ledger.note_op(it);
    end
    if (!rst && out_valid && out_ready) begin
      got.x = r_x; got.y = r_y; got.inf = r_inf; got.onc = on_curve;
      ledger.check_point(got);
    end
  end

  // receiver: random stalls, a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready = 0;
        stall--;
      end else begin
        out_ready = ($urandom_range(0, 99) < 75);
        if ($urandom_range(0, 199) == 0) stall = $urandom_range(20, 300);
      end
    end
  end

  // register write, setup then access cycle
  task write_reg(logic [epa_pkg::APB_AW-1:0] addr, logic [31:0] v);
    psel = 1; pwrite = 1; penable = 0; paddr = addr; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ledger.set_reg(addr, v);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task drain();
    while (ledger.pending_pts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task set_curve(logic [31:0] m, logic [31:0] a, logic [31:0] b);
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_CURVE_A, a);
    write_reg(REG_CURVE_B, b);
  endtask

  // one input transfer then a random, possibly empty gap
  task send_op(op_item_t it);
    int r, gap;
    kind = it.kind; p_x = it.px; p_y = it.py; p_inf = it.pinf;
    q_x = it.qx; q_y = it.qy; q_inf = it.qinf; scalar = it.k;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(20, 200);
    if (gap > 0) begin
      repeat (gap) @(negedge clk);
    end
  endtask

  function logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e);
    logic [63:0] acc;
    acc = ledger.red(1);
    while (e != 0) begin
      if (e[0]) acc = ledger.mmul(acc, b);
      b = ledger.mmul(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  // a point on the current curve where one is found, else random coordinates
  task pick_point(output logic [30:0] x, output logic [30:0] y);
    logic [63:0] rhs, cand, m;
    m = ledger.fmod;
    for (int tr = 0; tr < 20; tr++) begin
      x = 31'($urandom_range(0, int'(m - 1)));
      rhs = ledger.red(ledger.mmul(ledger.mmul(x, x), x) +
                       ledger.mmul(ledger.red(ledger.ca), x) + ledger.red(ledger.cb));
      cand = mod_pow(rhs, (m + 1) >> 2);
      if (ledger.mmul(cand, cand) == rhs) begin
        y = cand[30:0];
        return;
      end
      if (m <= 5000) begin
        for (logic [63:0] c = 0; c < m; c++) begin
          if (ledger.mmul(c, c) == rhs) begin
            y = c[30:0];
            return;
          end
        end
      end
    end
    y = 31'($urandom_range(0, int'(m - 1)));
  endtask

  function op_item_t mk(op_kind_t kd, logic [30:0] px, logic [30:0] py, logic pi,
                        logic [30:0] qx, logic [30:0] qy, logic qi, logic [31:0] k);
    op_item_t it;
    it.kind = kd; it.px = px; it.py = py; it.pinf = pi;
    it.qx = qx; it.qy = qy; it.qinf = qi; it.k = k;
    return it;
  endfunction

  function logic [31:0] small_scalar();
    logic [31:0] mag;
    mag = $urandom_range(0, 20);
    return $urandom_range(0, 1) ? 32'd0 - mag : mag;
  endfunction

  // random items, mostly points on the curve with related second operands
  task random_ops(int n);
    op_item_t it;
    logic [30:0] x1, y1, x2, y2;
    int sel;
    for (int i = 0; i < n; i++) begin
      it.kind = op_kind_t'($urandom_range(0, 3));
      it.k = ($urandom_range(0, 59) == 0) ? $urandom : small_scalar();
      if ($urandom_range(0, 3) != 0) begin
        pick_point(x1, y1);
        pick_point(x2, y2);
        sel = $urandom_range(0, 3);
        it.px = x1; it.py = y1;
        it.qx = (sel == 3) ? x2 : x1;
        it.qy = (sel == 1) ? 31'(ledger.msub(0, y1)) : (sel == 3) ? y2 : y1;
        it.pinf = ($urandom_range(0, 9) == 0);
        it.qinf = ($urandom_range(0, 9) == 0);
      end else begin
        it.px = 31'($urandom); it.py = 31'($urandom);
        it.qx = 31'($urandom); it.qy = 31'($urandom);
        it.pinf = 1'($urandom_range(0, 1)); it.qinf = 1'($urandom_range(0, 1));
      end
      send_op(it);
    end
  endtask

  // main sequence
  initial begin
    logic [30:0] x1, y1, x2, y2, ny;
    ledger = new();
    hold_cycles = 0;
    rst = 1; in_valid = 0; kind = 0; p_x = 0; p_y = 0; p_inf = 0;
    q_x = 0; q_y = 0; q_inf = 0; scalar = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed on the reset curve
    pick_point(x1, y1);
    pick_point(x2, y2);
    ny = 31'(ledger.msub(0, y1));
    send_op(mk(OP_ADD, x1, y1, 1, x2, y2, 0, 0));
    send_op(mk(OP_ADD, x1, y1, 0, x2, y2, 1, 0));
    send_op(mk(OP_ADD, x1, y1, 1, x2, y2, 1, 0));
    send_op(mk(OP_ADD, x1, y1, 0, x1, ny, 0, 0));
    send_op(mk(OP_ADD, x1, y1, 0, x1, y1, 0, 0));
    send_op(mk(OP_ADD, x1, y1, 0, x2, y2, 0, 0));
    send_op(mk(OP_ADD, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0, 0, 0, 0));
    send_op(mk(OP_DBL, x1, 0, 0, 0, 0, 0, 0));
    send_op(mk(OP_DBL, x1, y1, 1, 0, 0, 0, 0));
    send_op(mk(OP_DBL, x1, y1, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 1, 32'hFFFFFFFF));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 0));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 1));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 32'hFFFFFFFF));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 5));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 32'd0 - 32'd7));
    send_op(mk(OP_MUL, x1, y1, 1, 0, 0, 0, 3));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 32'h80000000));
    send_op(mk(OP_MUL, x1, y1, 0, 0, 0, 0, 32'h7FFFFFFF));
    send_op(mk(OP_CHK, x1, y1, 0, 0, 0, 0, 0));
    send_op(mk(OP_CHK, x1, 31'(ledger.red(y1 + 1)), 0, 0, 0, 0, 0));
    send_op(mk(OP_CHK, x1, y1, 1, 0, 0, 0, 0));
    send_op(mk(OP_CHK, 31'(x1 + 97), 31'(y1 + 97), 0, 0, 0, 0, 0));
    send_op(mk(OP_CHK, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 1, 0));

    // random on the reset curve, receiver holds off so the input stalls
    hold_cycles = 30000;
    random_ops(25);

    set_curve(2147483647, 2147483646, 7);
    random_ops(25);
    set_curve(3, 0, 0);
    random_ops(20);
    set_curve(91, 200, 11);
    random_ops(20);
    set_curve(1019, 1, 1);
    random_ops(20);
    set_curve(7, 6, 2147483646);
    random_ops(20);

    // let the last results arrive
    while (ledger.pending_pts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
